// ===== sv/ptbl_pkg.sv =====
// Shared types and constants for the per-source token bucket limiter.
// No dependencies; compiled first.
package ptbl_pkg;

    localparam logic [1:0] CMD_CHECK = 2'd0;
    localparam logic [1:0] CMD_SWEEP = 2'd1;
    localparam logic [1:0] CMD_CLEAR = 2'd2;

    localparam logic [1:0] FAM_V4 = 2'd0;
    localparam logic [1:0] FAM_V6 = 2'd1;

    localparam logic [1:0] REG_COST     = 2'd0;
    localparam logic [1:0] REG_CAPACITY = 2'd1;
    localparam logic [1:0] REG_LIMIT    = 2'd2;
    localparam logic [1:0] REG_TIMEOUT  = 2'd3;

    localparam logic [31:0] COST_RST     = 32'd50000000;
    localparam logic [39:0] CAPACITY_RST = 40'd250000000;
    localparam logic [10:0] LIMIT_RST    = 11'd1024;
    localparam logic [39:0] TIMEOUT_RST  = 40'd1000000000;

    typedef enum logic [1:0] {
        WR_NONE,
        WR_INVAL,
        WR_HIT,
        WR_INS
    } t_wr_kind;

    typedef struct packed {
        logic     load;
        logic     addr_clr;
        logic     addr_inc;
        logic     addr_hit;
        logic     addr_free;
        logic     scan_clr;
        logic     scan_eval;
        logic     calc1;
        logic     calc2;
        t_wr_kind wr;
        logic     cnt_inc;
        logic     cnt_dec;
    } t_dp_cmd;

    typedef struct packed {
        logic [1:0]  cmd;
        logic        fam_bad;
        logic        addr_last;
        logic        hit;
        logic        free;
        logic        full;
        logic        stale;
        logic        ok;
        logic [10:0] count;
    } t_dp_sts;

endpackage

// ===== sv/ptbl_in_if.sv =====
// Input channel of the limiter: valid/ready plus one item word.
// Depends on nothing.
interface ptbl_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  command;
    logic [1:0]  address_family;
    logic [15:0] namespace_id;
    logic [63:0] source_key;
    logic [63:0] time_ns;

    modport source (output valid, command, address_family, namespace_id, source_key, time_ns,
                    input ready);
    modport sink (input valid, command, address_family, namespace_id, source_key, time_ns,
                  output ready);
endinterface

// ===== sv/ptbl_out_if.sv =====
// Result channel of the limiter: valid/ready plus one result word.
// Depends on nothing.
interface ptbl_out_if;
    logic        valid;
    logic        ready;
    logic        allowed;
    logic [10:0] entries_in_use;

    modport source (output valid, allowed, entries_in_use, input ready);
    modport sink (input valid, allowed, entries_in_use, output ready);
endinterface

// ===== sv/ptbl_datapath.sv =====
// Datapath: config registers, item latch, bucket table memory, refill arithmetic.
// Depends on ptbl_pkg.
module ptbl_datapath import ptbl_pkg::*; #(
    parameter int ENTRIES        = 1024,
    parameter int NAMESPACE_BITS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [39:0] i_cfg_data,
    input  logic [1:0]  i_command,
    input  logic [1:0]  i_address_family,
    input  logic [15:0] i_namespace_id,
    input  logic [63:0] i_source_key,
    input  logic [63:0] i_time_ns,
    input  t_dp_cmd     i_cmd,
    output t_dp_sts     o_sts
);
    localparam int AW = $clog2(ENTRIES);
    localparam int CW = $clog2(ENTRIES + 1);

    typedef struct packed {
        logic                      valid;
        logic                      fam;
        logic [NAMESPACE_BITS-1:0] ns;
        logic [63:0]               src;
        logic [63:0]               last;
        logic [39:0]               tok;
    } t_entry;

    logic [31:0] r_cost;
    logic [39:0] r_cap;
    logic [10:0] r_limit;
    logic [39:0] r_tmo;

    logic [1:0]                r_cmd;
    logic [1:0]                r_fam;
    logic [NAMESPACE_BITS-1:0] r_ns;
    logic [63:0]               r_src;
    logic [63:0]               r_now;

    t_entry        r_mem [ENTRIES];
    t_entry        r_rd;
    t_entry        n_wdata;
    logic [AW-1:0] r_addr;
    logic          r_hit;
    logic          r_free;
    logic [AW-1:0] r_hit_idx;
    logic [AW-1:0] r_free_idx;
    logic [39:0]   r_tok;
    logic [63:0]   r_last;
    logic [63:0]   r_el;
    logic [39:0]   r_room;
    logic          r_full;
    logic [39:0]   r_newtok;
    logic [CW-1:0] r_live;

    logic [31:0]               ns_wide;
    logic [NAMESPACE_BITS-1:0] ns_key;
    logic                      match;
    logic                      ok;
    logic [39:0]               ins_tok;

    assign ns_wide = {16'b0, i_namespace_id};
    assign ns_key  = ns_wide[NAMESPACE_BITS-1:0];

    assign match = r_rd.valid && (r_rd.fam == r_fam[0]) && (r_rd.ns == r_ns)
                   && (r_rd.src == r_src);
    assign ok      = r_newtok >= {8'b0, r_cost};
    assign ins_tok = (r_cap >= {8'b0, r_cost}) ? r_cap - {8'b0, r_cost} : 40'd0;

    always_comb begin
        o_sts.cmd       = r_cmd;
        o_sts.fam_bad   = r_fam != FAM_V4 && r_fam != FAM_V6;
        o_sts.addr_last = r_addr == AW'(ENTRIES - 1);
        o_sts.hit       = r_hit;
        o_sts.free      = r_free;
        o_sts.full      = 32'(r_live) >= 32'(r_limit);
        o_sts.stale     = r_rd.valid && (r_cmd == CMD_CLEAR ||
                          (r_now >= r_rd.last && (r_now - r_rd.last) > {24'b0, r_tmo}));
        o_sts.ok        = ok;
        o_sts.count     = 11'(r_live);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cost  <= COST_RST;
            r_cap   <= CAPACITY_RST;
            r_limit <= LIMIT_RST;
            r_tmo   <= TIMEOUT_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_COST:     r_cost  <= i_cfg_data[31:0];
                REG_CAPACITY: r_cap   <= i_cfg_data;
                REG_LIMIT:    r_limit <= i_cfg_data[10:0];
                REG_TIMEOUT:  r_tmo   <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // item latch; IPv4 keys use only the low address word
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cmd <= CMD_CHECK;
        end else if (i_cmd.load) begin
            r_cmd <= i_command;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_fam <= i_address_family;
            r_ns  <= ns_key;
            r_src <= (i_address_family == FAM_V4) ? {32'b0, i_source_key[31:0]} : i_source_key;
            r_now <= i_time_ns;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_addr <= '0;
            r_live <= '0;
            r_hit  <= 1'b0;
            r_free <= 1'b0;
        end else begin
            if (i_cmd.addr_clr) begin
                r_addr <= '0;
            end else if (i_cmd.addr_inc) begin
                r_addr <= r_addr + AW'(1);
            end else if (i_cmd.addr_hit) begin
                r_addr <= r_hit_idx;
            end else if (i_cmd.addr_free) begin
                r_addr <= r_free_idx;
            end
            if (i_cmd.cnt_inc) begin
                r_live <= r_live + CW'(1);
            end else if (i_cmd.cnt_dec) begin
                r_live <= r_live - CW'(1);
            end
            if (i_cmd.scan_clr) begin
                r_hit  <= 1'b0;
                r_free <= 1'b0;
            end else if (i_cmd.scan_eval) begin
                if (match) r_hit <= 1'b1;
                if (!r_rd.valid) r_free <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.scan_eval) begin
            if (match) begin
                r_hit_idx <= r_addr;
                r_tok     <= r_rd.tok;
                r_last    <= r_rd.last;
            end
            if (!r_rd.valid && !r_free) r_free_idx <= r_addr;
        end
        if (i_cmd.calc1) begin
            r_el   <= (r_now >= r_last) ? r_now - r_last : 64'd0;
            r_full <= r_tok >= r_cap;
            r_room <= r_cap - r_tok;
        end
        if (i_cmd.calc2) begin
            r_newtok <= (r_full || r_el >= {24'b0, r_room}) ? r_cap : r_tok + r_el[39:0];
        end
    end

    always_comb begin
        n_wdata = r_rd;
        case (i_cmd.wr)
            WR_INVAL: n_wdata.valid = 1'b0;
            WR_HIT: begin
                n_wdata.valid = 1'b1;
                n_wdata.fam   = r_fam[0];
                n_wdata.ns    = r_ns;
                n_wdata.src   = r_src;
                n_wdata.last  = r_now;
                n_wdata.tok   = ok ? r_newtok - {8'b0, r_cost} : r_newtok;
            end
            WR_INS: begin
                n_wdata.valid = 1'b1;
                n_wdata.fam   = r_fam[0];
                n_wdata.ns    = r_ns;
                n_wdata.src   = r_src;
                n_wdata.last  = r_now;
                n_wdata.tok   = ins_tok;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.wr != WR_NONE) begin
            r_mem[r_addr] <= n_wdata;
        end
        r_rd <= r_mem[r_addr];
    end
endmodule

// ===== sv/ptbl_ctrl.sv =====
// Controller: sequences table clear, scans, refill steps and the result register.
// Depends on ptbl_pkg.
module ptbl_ctrl import ptbl_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic        o_allowed,
    output logic [10:0] o_count,
    output t_dp_cmd     o_cmd,
    input  t_dp_sts     i_sts
);
    typedef enum logic [3:0] {
        ST_INIT,
        ST_IDLE,
        ST_DISP,
        ST_RD,
        ST_EV,
        ST_CALC1,
        ST_CALC2,
        ST_HWR,
        ST_INS,
        ST_RESP
    } t_state;

    t_state      r_state, n_state;
    logic        r_allowed, n_allowed;
    logic        r_out_valid, n_out_valid;
    logic        r_o_allowed, n_o_allowed;
    logic [10:0] r_o_count, n_o_count;

    assign o_in_ready  = r_state == ST_IDLE;
    assign o_out_valid = r_out_valid;
    assign o_allowed   = r_o_allowed;
    assign o_count     = r_o_count;

    always_comb begin
        n_state     = r_state;
        n_allowed   = r_allowed;
        n_out_valid = r_out_valid && !i_out_ready;
        n_o_allowed = r_o_allowed;
        n_o_count   = r_o_count;
        o_cmd       = '0;
        o_cmd.wr    = WR_NONE;
        case (r_state)
            ST_INIT: begin
                o_cmd.wr = WR_INVAL;
                o_cmd.addr_inc = 1'b1;
                if (i_sts.addr_last) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load     = 1'b1;
                    o_cmd.addr_clr = 1'b1;
                    o_cmd.scan_clr = 1'b1;
                    n_allowed      = 1'b0;
                    n_state        = ST_DISP;
                end
            end
            ST_DISP: begin
                if (i_sts.cmd == CMD_CHECK && i_sts.fam_bad) begin
                    n_state = ST_RESP;
                end else if (i_sts.cmd == CMD_CHECK || i_sts.cmd == CMD_SWEEP ||
                             i_sts.cmd == CMD_CLEAR) begin
                    n_state = ST_RD;
                end else begin
                    n_state = ST_RESP;
                end
            end
            ST_RD: n_state = ST_EV;
            ST_EV: begin
                if (i_sts.cmd == CMD_CHECK) begin
                    o_cmd.scan_eval = 1'b1;
                end else if (i_sts.stale) begin
                    o_cmd.wr      = WR_INVAL;
                    o_cmd.cnt_dec = 1'b1;
                end
                if (!i_sts.addr_last) begin
                    o_cmd.addr_inc = 1'b1;
                    n_state = ST_RD;
                end else if (i_sts.cmd != CMD_CHECK) begin
                    n_state = ST_RESP;
                end else begin
                    // flags are settled except for the last slot, fold it in here
                    n_state = ST_CALC1;
                end
            end
            ST_CALC1: begin
                if (i_sts.hit) begin
                    o_cmd.calc1    = 1'b1;
                    o_cmd.addr_hit = 1'b1;
                    n_state = ST_CALC2;
                end else if (i_sts.full || !i_sts.free) begin
                    n_state = ST_RESP;
                end else begin
                    o_cmd.addr_free = 1'b1;
                    n_state = ST_INS;
                end
            end
            ST_CALC2: begin
                o_cmd.calc2 = 1'b1;
                n_state = ST_HWR;
            end
            ST_HWR: begin
                o_cmd.wr  = WR_HIT;
                n_allowed = i_sts.ok;
                n_state   = ST_RESP;
            end
            ST_INS: begin
                o_cmd.wr      = WR_INS;
                o_cmd.cnt_inc = 1'b1;
                n_allowed     = 1'b1;
                n_state       = ST_RESP;
            end
            ST_RESP: begin
                if (!r_out_valid || i_out_ready) begin
                    n_out_valid = 1'b1;
                    n_o_allowed = r_allowed;
                    n_o_count   = i_sts.count;
                    n_state     = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_INIT;
            r_allowed   <= 1'b0;
            r_out_valid <= 1'b0;
            r_o_allowed <= 1'b0;
            r_o_count   <= '0;
        end else begin
            r_state     <= n_state;
            r_allowed   <= n_allowed;
            r_out_valid <= n_out_valid;
            r_o_allowed <= n_o_allowed;
            r_o_count   <= n_o_count;
        end
    end
endmodule

// ===== sv/per_source_token_bucket_limiter.sv =====
// Top level of the per-source token bucket limiter.
// Depends on ptbl_pkg, ptbl_in_if, ptbl_out_if, ptbl_datapath, ptbl_ctrl.
//
//   channel  dir  word
//   i_in     in   command, address_family, namespace_id, source_key, time_ns
//   o_out    out  allowed, entries_in_use
//   i_cfg_*  in   register write, index 0..3
//
// Check, sweep and clear walk every slot through the single table read port,
// reading a slot in ST_RD and evaluating it in ST_EV; after the walk a check
// runs ST_CALC1, then ST_CALC2 and ST_HWR on a hit or ST_INS on an insert.
// Unknown commands and other-family checks skip the table walk.
// After reset a clearing pass over every slot runs before the first word is taken.
// A result waiting at the output stalls only the finish of the following word.
module per_source_token_bucket_limiter import ptbl_pkg::*; #(
    parameter int ENTRIES        = 1024,
    parameter int NAMESPACE_BITS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    ptbl_in_if.sink     i_in,
    ptbl_out_if.source  o_out,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [39:0] i_cfg_data
);
    t_dp_cmd dp_cmd;
    t_dp_sts dp_sts;

    ptbl_datapath #(
        .ENTRIES        (ENTRIES),
        .NAMESPACE_BITS (NAMESPACE_BITS)
    ) u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_idx        (i_cfg_idx),
        .i_cfg_data       (i_cfg_data),
        .i_command        (i_in.command),
        .i_address_family (i_in.address_family),
        .i_namespace_id   (i_in.namespace_id),
        .i_source_key     (i_in.source_key),
        .i_time_ns        (i_in.time_ns),
        .i_cmd            (dp_cmd),
        .o_sts            (dp_sts)
    );

    ptbl_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .o_in_ready  (i_in.ready),
        .o_out_valid (o_out.valid),
        .i_out_ready (o_out.ready),
        .o_allowed   (o_out.allowed),
        .o_count     (o_out.entries_in_use),
        .o_cmd       (dp_cmd),
        .i_sts       (dp_sts)
    );
endmodule

// ===== tb/per_source_token_bucket_limiter_tb.sv =====
// Self-checking testbench for per_source_token_bucket_limiter: directed and random
// packet checks, sweeps and clears against a behavioral bucket table.
// Depends on ptbl_pkg, ptbl_in_if, ptbl_out_if and the limiter RTL.
module per_source_token_bucket_limiter_tb;
    import ptbl_pkg::*;

    localparam int  SLOTS     = 1024;
    localparam int  SLOT_TIME = 2 * SLOTS + 16;   // one full table walk, with margin
    localparam longint CYCLE_LIMIT = 40_000_000;
    localparam logic [1:0] CMD_UNKNOWN = 2'd3;
    localparam logic [1:0] FAM_OTHER   = 2'd2;
    localparam logic [1:0] FAM_RSVD    = 2'd3;

    typedef struct {
        logic [1:0]  cmd;
        logic [1:0]  fam;
        logic [15:0] ns;
        logic [63:0] src;
        logic [63:0] tm;
    } t_pkt;

    typedef struct {
        logic        allowed;
        logic [10:0] in_use;
    } t_verdict;

    logic i_clk = 1'b0;
    logic i_rst_n;
    logic i_cfg_we;
    logic [1:0] i_cfg_idx;
    logic [39:0] i_cfg_data;

    ptbl_in_if  in_ch();
    ptbl_out_if out_ch();

    per_source_token_bucket_limiter dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (in_ch),
        .o_out      (out_ch),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    always #10 i_clk = ~i_clk;

    // bucket table mirror
    logic [31:0] cost;
    logic [39:0] capacity;
    logic [10:0] limit;
    logic [39:0] timeout;
    bit          b_valid [SLOTS];
    logic        b_fam   [SLOTS];
    logic [15:0] b_ns    [SLOTS];
    logic [63:0] b_src   [SLOTS];
    logic [63:0] b_seen  [SLOTS];
    logic [39:0] b_tok   [SLOTS];
    int          live;

    t_pkt     pending [$];
    t_verdict verdicts [$];
    int  errors, n_allowed, n_denied, n_sweeps, n_hits;
    int  mode;          // 0 none, 1 sender gaps, 2 receiver stalls, 3 both light
    bit  hold_off;
    bit  in_took;
    longint cyc;
    logic [63:0] now;
    t_pkt   drv;

    function automatic logic [63:0] elapsed(logic [63:0] t, logic [63:0] then);
        return (t >= then) ? t - then : 64'd0;
    endfunction

    function automatic logic check_packet(t_pkt p);
        logic [63:0] key;
        logic [63:0] el;
        logic [63:0] tok;
        logic ok;
        if (p.fam > FAM_V6)
            return 1'b0;
        key = (p.fam == FAM_V4) ? {32'd0, p.src[31:0]} : p.src;
        for (int i = 0; i < SLOTS; i++) begin
            if (b_valid[i] && b_fam[i] == p.fam[0] && b_ns[i] == p.ns && b_src[i] == key) begin
                el  = elapsed(p.tm, b_seen[i]);
                tok = {24'd0, b_tok[i]};
                if (tok >= {24'd0, capacity} || el >= {24'd0, capacity} - tok)
                    tok = {24'd0, capacity};
                else
                    tok = tok + el;
                b_seen[i] = p.tm;
                ok = tok >= {32'd0, cost};
                b_tok[i] = ok ? 40'(tok - {32'd0, cost}) : 40'(tok);
                n_hits++;
                return ok;
            end
        end
        if (live >= int'(limit))
            return 1'b0;
        for (int i = 0; i < SLOTS; i++) begin
            if (!b_valid[i]) begin
                b_valid[i] = 1'b1;
                b_fam[i]   = p.fam[0];
                b_ns[i]    = p.ns;
                b_src[i]   = key;
                b_seen[i]  = p.tm;
                b_tok[i]   = (capacity >= {8'd0, cost}) ? capacity - {8'd0, cost} : 40'd0;
                live++;
                return 1'b1;
            end
        end
        return 1'b0;
    endfunction

    function automatic void age_out(logic [63:0] t, bit all);
        for (int i = 0; i < SLOTS; i++)
            if (b_valid[i] && (all || elapsed(t, b_seen[i]) > {24'd0, timeout})) begin
                b_valid[i] = 1'b0;
                live--;
            end
    endfunction

    function automatic t_verdict predict_verdict(t_pkt p);
        t_verdict v;
        v.allowed = 1'b0;
        case (p.cmd)
            CMD_CHECK: v.allowed = check_packet(p);
            CMD_SWEEP: age_out(p.tm, 1'b0);
            CMD_CLEAR: age_out(p.tm, 1'b1);
            default: ;
        endcase
        v.in_use = 11'(live);
        return v;
    endfunction

    task automatic report(string what, logic [63:0] got, logic [63:0] want);
        $display("mismatch %0s: got %0d expected %0d (cycle %0d)", what, got, want, cyc);
        errors++;
    endtask

    // driver
    always @(negedge i_clk) begin
        if (i_rst_n && (!in_ch.valid || in_took)) begin
            if (pending.size() > 0 &&
                !((mode == 1 && $urandom_range(99) < 66) ||
                  (mode == 3 && $urandom_range(99) < 10))) begin
                drv = pending.pop_front();
                in_ch.command        <= drv.cmd;
                in_ch.address_family <= drv.fam;
                in_ch.namespace_id   <= drv.ns;
                in_ch.source_key     <= drv.src;
                in_ch.time_ns        <= drv.tm;
                in_ch.valid          <= 1'b1;
            end else begin
                in_ch.valid <= 1'b0;
            end
        end
    end

    always @(negedge i_clk)
        out_ch.ready <= !hold_off && !((mode == 2 && $urandom_range(99) < 66) ||
                                       (mode == 3 && $urandom_range(99) < 10));

    // acceptance, prediction and result check
    always @(posedge i_clk) begin
        t_pkt p;
        t_verdict v;
        cyc <= cyc + 1;
        if (cyc > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cyc);
            $display("FAILURE");
            $finish;
        end
        in_took <= in_ch.valid && in_ch.ready;
        if (i_rst_n && in_ch.valid && in_ch.ready) begin
            p.cmd = in_ch.command;
            p.fam = in_ch.address_family;
            p.ns  = in_ch.namespace_id;
            p.src = in_ch.source_key;
            p.tm  = in_ch.time_ns;
            v = predict_verdict(p);
            if (p.cmd == CMD_CHECK && p.fam <= FAM_V6) begin
                if (v.allowed) n_allowed++; else n_denied++;
            end
            if (p.cmd == CMD_SWEEP) n_sweeps++;
            verdicts.push_back(v);
        end
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            if (verdicts.size() == 0) begin
                report("unexpected word, entries_in_use", 64'(out_ch.entries_in_use), 64'd0);
            end else begin
                v = verdicts.pop_front();
                if (out_ch.allowed !== v.allowed)
                    report("allowed", 64'(out_ch.allowed), 64'(v.allowed));
                if (out_ch.entries_in_use !== v.in_use)
                    report("entries_in_use", 64'(out_ch.entries_in_use), 64'(v.in_use));
            end
        end
    end

    task automatic write_reg(logic [1:0] idx, logic [39:0] val);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            REG_COST:     cost     = val[31:0];
            REG_CAPACITY: capacity = val;
            REG_LIMIT:    limit    = val[10:0];
            default:      timeout  = val;
        endcase
    endtask

    task automatic wait_idle();
        while (pending.size() > 0 || in_ch.valid || verdicts.size() > 0)
            @(posedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic push(logic [1:0] c, logic [1:0] f, logic [15:0] n, logic [63:0] s,
                        logic [63:0] t);
        t_pkt p;
        p.cmd = c; p.fam = f; p.ns = n; p.src = s; p.tm = t;
        pending.push_back(p);
    endtask

    // random time step, mostly around the cost so refills both cover and fall short
    function automatic logic [63:0] step_time();
        if ($urandom_range(19) == 0)
            return {$urandom, $urandom} >> $urandom_range(63);
        return (64'($urandom) * 64'(cost)) >> 31;
    endfunction

    logic [1:0]  pool_fam [16];
    logic [15:0] pool_ns  [16];
    logic [63:0] pool_src [16];

    initial begin
        logic [31:0] costs [8];
        logic [39:0] caps  [8];
        logic [10:0] limits [8];
        logic [39:0] touts [8];
        int k, r;
        logic [1:0] c, f;

        costs  = '{32'd50000000, 32'd1, 32'hFFFF_FFFF, 32'd1000,
                   32'd7, 32'd123456, 32'd50000000, 32'd300};
        caps   = '{40'd250000000, 40'd3, 40'hFF_FFFF_FFFF, 40'd2500,
                   40'd1, 40'd400000, 40'hFF_FFFF_FFFF, 40'd1000};
        limits = '{11'd1024, 11'd1, 11'd3, 11'd8, 11'd1024, 11'd2,
                   11'd12, 11'd1024};
        touts  = '{40'd1000000000, 40'd1, 40'hFF_FFFF_FFFF, 40'd5000,
                   40'd100, 40'd900000, 40'd1000000000, 40'd2000};
        errors = 0; n_allowed = 0; n_denied = 0; n_sweeps = 0; n_hits = 0;
        mode = 0; hold_off = 0; in_took = 0; cyc = 0;
        cost = COST_RST; capacity = CAPACITY_RST; limit = LIMIT_RST; timeout = TIMEOUT_RST;
        live = 0;
        foreach (b_valid[i]) b_valid[i] = 1'b0;
        in_ch.valid = 1'b0; in_ch.command = '0; in_ch.address_family = '0;
        in_ch.namespace_id = '0; in_ch.source_key = '0; in_ch.time_ns = '0;
        out_ch.ready = 1'b0;
        i_cfg_we = 1'b0; i_cfg_idx = '0; i_cfg_data = '0;
        i_rst_n = 1'b0;
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed: keying, other family, unknown command, time edges, sweep, clear
        push(CMD_CHECK, FAM_V4, 16'd0, 64'h0000_0000_0A00_0001, 64'd1000);
        push(CMD_CHECK, FAM_V4, 16'd0, 64'hFFFF_FFFF_0A00_0001, 64'd2000);  // upper bits ignored
        push(CMD_CHECK, FAM_V6, 16'd0, 64'h0000_0000_0A00_0001, 64'd2000);
        push(CMD_CHECK, FAM_V6, 16'hFFFF, 64'hFFFF_FFFF_FFFF_FFFF, 64'd3000);
        push(CMD_CHECK, FAM_OTHER, 16'd5, 64'd1, 64'd3000);
        push(CMD_CHECK, FAM_RSVD, 16'd5, 64'd1, 64'd3000);
        push(CMD_UNKNOWN, FAM_V4, 16'd0, 64'd0, 64'd3000);
        for (int i = 0; i < 5; i++)   // drain the bucket, then refused
            push(CMD_CHECK, FAM_V4, 16'd0, 64'h0A00_0001, 64'd2500);
        push(CMD_CHECK, FAM_V4, 16'd0, 64'h0A00_0001, 64'd10);      // time goes back
        push(CMD_SWEEP, FAM_V4, 16'd0, 64'd0, 64'd0);               // backwards: none removed
        push(CMD_CHECK, FAM_V6, 16'hFFFF, 64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF);
        push(CMD_SWEEP, FAM_V4, 16'd0, 64'd0, 64'hFFFF_FFFF_FFFF_FFFF);
        push(CMD_CHECK, FAM_V4, 16'h1234, 64'h55, 64'd100);
        push(CMD_CLEAR, FAM_V4, 16'd0, 64'd0, 64'd0);
        push(CMD_CHECK, FAM_V4, 16'h1234, 64'h55, 64'd100);
        wait_idle();
        write_reg(REG_CAPACITY, 40'd1000);                          // below held tokens
        push(CMD_CHECK, FAM_V4, 16'h1234, 64'h55, 64'd200);
        wait_idle();
        write_reg(REG_COST, 40'h00_FFFF_FFFF);                      // cost above capacity
        push(CMD_CHECK, FAM_V6, 16'd7, 64'd77, 64'd300);
        push(CMD_CHECK, FAM_V6, 16'd7, 64'd77, 64'd400);
        wait_idle();
        write_reg(REG_LIMIT, 40'd0);
        push(CMD_CHECK, FAM_V6, 16'd8, 64'd88, 64'd500);
        wait_idle();
        write_reg(REG_LIMIT, 40'd3);
        push(CMD_CHECK, FAM_V6, 16'd9, 64'd99, 64'd600);
        push(CMD_CHECK, FAM_V6, 16'd10, 64'd100, 64'd600);          // table at limit
        wait_idle();

        // random phases, each with its own register setting and idling pattern
        now = 64'd0;
        for (int ph = 0; ph < 8; ph++) begin
            write_reg(REG_COST, {8'd0, costs[ph]});
            write_reg(REG_CAPACITY, caps[ph]);
            write_reg(REG_LIMIT, {29'd0, limits[ph]});
            write_reg(REG_TIMEOUT, touts[ph]);
            mode = ph % 4;
            for (int i = 0; i < 16; i++) begin
                pool_fam[i] = 2'($urandom_range(1));
                pool_ns[i]  = (i < 8) ? 16'($urandom_range(3)) : 16'($urandom);
                pool_src[i] = {$urandom, $urandom};
            end
            if (ph == 2)
                fork
                    begin
                        repeat (30) @(negedge i_clk);
                        hold_off = 1'b1;
                        repeat (12000) @(negedge i_clk);
                        hold_off = 1'b0;
                    end
                join_none
            for (int i = 0; i < 150; i++) begin
                r = $urandom_range(99);
                k = $urandom_range(15);
                now = now + step_time();
                if ($urandom_range(30) == 0)
                    now = now - ({$urandom, $urandom} >> $urandom_range(63));
                c = CMD_CHECK; f = pool_fam[k];
                if (r < 5)       c = CMD_SWEEP;
                else if (r < 6)  c = CMD_CLEAR;
                else if (r < 8)  c = CMD_UNKNOWN;
                else if (r < 11) f = ($urandom_range(1) == 0) ? FAM_OTHER : FAM_RSVD;
                if (r >= 90)
                    push(c, 2'($urandom_range(1)), 16'($urandom), {$urandom, $urandom}, now);
                else if (pool_fam[k] == FAM_V4 && $urandom_range(1) == 1)
                    push(c, f, pool_ns[k], {$urandom, pool_src[k][31:0]}, now);
                else
                    push(c, f, pool_ns[k], pool_src[k], now);
            end
            wait_idle();
        end

        while (verdicts.size() > 0) @(posedge i_clk);
        repeat (SLOT_TIME) @(posedge i_clk);
        $display("checks allowed %0d, denied %0d, bucket hits %0d, sweeps %0d",
                 n_allowed, n_denied, n_hits, n_sweeps);
        $display("eight register settings, four idling patterns, one long output stall");
        if (errors == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end
endmodule

// ===== filelist.f =====
sv/ptbl_pkg.sv
sv/ptbl_in_if.sv
sv/ptbl_out_if.sv
sv/ptbl_datapath.sv
sv/ptbl_ctrl.sv
sv/per_source_token_bucket_limiter.sv
tb/per_source_token_bucket_limiter_tb.sv
